/* rtl/ofsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ofsa_pkg;

  // Pool geometry: the 5-bit result index caps the pool at 32 slots.
  localparam int unsigned MAX_SURFACES = 32;
  localparam int unsigned IDX_W        = $clog2(MAX_SURFACES);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned AGE_W        = 64;
  localparam int unsigned STATUS_W     = 2;

  localparam logic [CNT_W-1:0] POOL_SIZE_RESET = CNT_W'(20);
  localparam logic [CNT_W-1:0] ACTIVE_LIMIT    = CNT_W'(MAX_SURFACES);

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_RELEASED = 2'd2,
    ST_BAD_IDX  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FINISH
  } fsm_e;

  // Control handed from the sequencer to the min-search unit each cycle.
  typedef struct packed {
    logic             clear;
    logic             valid;
    logic             used;
    logic [IDX_W-1:0] tag;
  } scan_ctl_t;

endpackage

`default_nettype wire

/* rtl/ofsa_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ofsa_in_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [ofsa_pkg::IDX_W-1:0] surface_index;

  modport source  (output valid, output command, output surface_index, input ready);
  modport sink    (input valid, input command, input surface_index, output ready);
  modport monitor (input valid, input command, input surface_index, input ready);
endinterface

interface ofsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [ofsa_pkg::STATUS_W-1:0] status;
  logic [ofsa_pkg::IDX_W-1:0]    result_index;

  modport source  (output valid, output status, output result_index, input ready);
  modport sink    (input valid, input status, input result_index, output ready);
  modport monitor (input valid, input status, input result_index, input ready);
endinterface

interface ofsa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ofsa_pkg::CNT_W-1:0] pool_size;

  modport source  (output valid, output pool_size, input ready);
  modport sink    (input valid, input pool_size, output ready);
  modport monitor (input valid, input pool_size, input ready);
endinterface

`default_nettype wire

/* rtl/ofsa_age_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module ofsa_age_mem (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       we_i,
  input  wire logic [ofsa_pkg::IDX_W-1:0] waddr_i,
  input  wire logic [ofsa_pkg::AGE_W-1:0] wdata_i,
  input  wire logic [ofsa_pkg::IDX_W-1:0] raddr_i,
  output      logic [ofsa_pkg::AGE_W-1:0] rdata_o
);
  import ofsa_pkg::*;

  logic [AGE_W-1:0]        mem [MAX_SURFACES];
  logic [MAX_SURFACES-1:0] written_q;
  logic [AGE_W-1:0]        rdata_q;
  logic                    rd_written_q;

  // written bits stand in for the all-zero reset of the age store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      rd_written_q <= written_q[raddr_i];
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rd_written_q ? rdata_q : '0;

endmodule

`default_nettype wire

/* rtl/ofsa_min_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module ofsa_min_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ofsa_pkg::scan_ctl_t        ctl_i,
  input  wire logic [ofsa_pkg::AGE_W-1:0] age_i,
  output      logic                       found_o,
  output      logic [ofsa_pkg::IDX_W-1:0] best_idx_o
);
  import ofsa_pkg::*;

  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [AGE_W-1:0] best_age_q;
  logic             older;
  logic             take;

  // strict less-than keeps the lowest index on equal ages
  assign older = age_i < best_age_q;
  assign take  = ctl_i.valid && !ctl_i.used && (!found_q || older);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctl_i.clear) begin
      best_idx_q <= ctl_i.tag;
      best_age_q <= age_i;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;

endmodule

`default_nettype wire

/* rtl/oldest_free_slot_allocator_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Allocate: the scan covers pool_size slots (capped at 32) between accept and result word.
//   One slot per cycle through the age memory read port and the shared 64-bit compare.
// Release: no scan, straight to the result word. One word in flight; in ready only when idle.
// Reset (rst_ni, async, active low): all slots free, ages and age counter zero,
//   pool_size back to 20. No clearing pass; usable as soon as reset is released.
module oldest_free_slot_allocator_core (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  ofsa_in_if.sink        in_i,
  ofsa_out_if.source     out_o,
  ofsa_cfg_if.sink       cfg_i
);
  import ofsa_pkg::*;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  fsm_e                    state_q, state_d;
  logic [CNT_W-1:0]        pool_size_q;
  logic [MAX_SURFACES-1:0] slot_used_q;
  logic [AGE_W-1:0]        age_cnt_q;

  // latched command word
  cmd_e                    cmd_q;
  logic [IDX_W-1:0]        idx_q;

  // scan pipeline: issue counter, then the registered memory read (rd_vld_q, rd_tag_q)
  logic [CNT_W-1:0]        iss_cnt_q;
  logic                    rd_vld_q;
  logic [IDX_W-1:0]        rd_tag_q;

  // output register
  logic                    out_valid_q;
  status_e                 out_status_q;
  logic [IDX_W-1:0]        out_idx_q;

  // ---------------------------------------------------------------------------
  // Combinational control
  // ---------------------------------------------------------------------------
  logic             in_acc;
  logic [CNT_W-1:0] active_n;
  logic             issue;
  logic             last_cmp;
  logic             scan_done;
  logic             out_free;
  logic             commit;
  logic             grant;
  logic             rel_ok;
  logic             mem_we;
  status_e          res_status;
  logic [IDX_W-1:0] res_idx;

  logic [AGE_W-1:0] age_rd;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  scan_ctl_t        scan_ctl;

  assign in_acc   = in_i.valid && in_i.ready;
  assign active_n = (pool_size_q > ACTIVE_LIMIT) ? ACTIVE_LIMIT : pool_size_q;
  assign out_free = !out_valid_q || out_o.ready;

  // last compare is the one whose tag is the top active slot
  assign last_cmp  = rd_vld_q && ({1'b0, rd_tag_q} == (active_n - CNT_W'(1)));
  assign scan_done = (active_n == '0) || last_cmp;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          state_d = (cmd_e'(in_i.command) == CMD_ALLOC) ? FSM_SCAN : FSM_FINISH;
        end
      end
      FSM_SCAN: begin
        if (scan_done) begin
          state_d = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    issue      = 1'b0;
    commit     = 1'b0;
    grant      = 1'b0;
    rel_ok     = 1'b0;
    mem_we     = 1'b0;
    res_status = ST_NO_FREE;
    res_idx    = '0;
    case (state_q)
      FSM_SCAN: begin
        issue = iss_cnt_q < active_n;
      end
      FSM_FINISH: begin
        commit = out_free;
        if (cmd_q == CMD_ALLOC) begin
          if (found) begin
            grant      = commit;
            mem_we     = commit;
            res_status = ST_GRANTED;
            res_idx    = best_idx;
          end
        end else begin
          res_idx = idx_q;
          if ({1'b0, idx_q} < active_n) begin
            rel_ok     = commit;
            res_status = ST_RELEASED;
          end else begin
            res_status = ST_BAD_IDX;
          end
        end
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared datapath
  // ---------------------------------------------------------------------------
  ofsa_age_mem u_age_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (best_idx),
    .wdata_i (age_cnt_q),
    .raddr_i (iss_cnt_q[IDX_W-1:0]),
    .rdata_o (age_rd)
  );

  assign scan_ctl.clear = in_acc;
  assign scan_ctl.valid = rd_vld_q;
  assign scan_ctl.used  = slot_used_q[rd_tag_q];
  assign scan_ctl.tag   = rd_tag_q;

  ofsa_min_unit u_min_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .age_i      (age_rd),
    .found_o    (found),
    .best_idx_o (best_idx)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      pool_size_q <= POOL_SIZE_RESET;
      slot_used_q <= '0;
      age_cnt_q   <= '0;
      iss_cnt_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (cfg_i.valid) begin
        pool_size_q <= cfg_i.pool_size;
      end
      if (in_acc) begin
        iss_cnt_q <= '0;
      end else if (issue) begin
        iss_cnt_q <= iss_cnt_q + CNT_W'(1);
      end
      if (grant) begin
        slot_used_q[best_idx] <= 1'b1;
        age_cnt_q             <= age_cnt_q + AGE_W'(1);
      end else if (rel_ok) begin
        slot_used_q[idx_q] <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_e'(in_i.command);
      idx_q <= in_i.surface_index;
    end
    if (issue) begin
      rd_tag_q <= iss_cnt_q[IDX_W-1:0];
    end
    if (commit) begin
      out_status_q <= res_status;
      out_idx_q    <= res_idx;
    end
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign in_i.ready         = (state_q == FSM_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.result_index = out_idx_q;

endmodule

`default_nettype wire

/* rtl/ofsa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ofsa_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [ofsa_pkg::STATUS_W-1:0] out_status_i,
  input wire logic [ofsa_pkg::IDX_W-1:0]    out_idx_i
);
  import ofsa_pkg::*;

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_status_i) && $stable(out_idx_i))
    else $error("result word changed while stalled");

  // one command word in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command word taken while previous one in flight");

  a_no_free_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_NO_FREE) |-> (out_idx_i == '0))
    else $error("no-free result carries nonzero index");

endmodule

bind oldest_free_slot_allocator_core ofsa_checker u_ofsa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_idx_i    (out_o.result_index)
);

`default_nettype wire
